// File: rtl/cle_pkg.sv
// Shared constants, codes and controller/datapath interface types for the line editor.
package cle_pkg;

  localparam int LINE_DEPTH = 32;
  localparam int IDX_W      = $clog2(LINE_DEPTH);
  localparam int CHAR_W     = 7;
  localparam int LEN_W      = 6;
  localparam int RX_W       = 8;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(32);

  // Register index of max_line_len.
  localparam logic [0:0] REG_MAX_LINE_LEN = 1'b0;

  localparam logic [CHAR_W-1:0] CH_CR      = 7'h0d;
  localparam logic [CHAR_W-1:0] CH_LF      = 7'h0a;
  localparam logic [CHAR_W-1:0] CH_BS      = 7'h08;
  localparam logic [CHAR_W-1:0] CH_DEL     = 7'h7f;
  localparam logic [CHAR_W-1:0] CH_CTRLP   = 7'h10;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 7'h20;
  localparam logic [CHAR_W-1:0] PRINT_BITS = 7'h60;
  localparam logic [CHAR_W-1:0] CH_NUL     = 7'h00;

  typedef enum logic [2:0] {
    SRC_CR,
    SRC_LF,
    SRC_BS,
    SRC_SP,
    SRC_CHAR,
    SRC_STORE,
    SRC_PEND
  } src_t;

  typedef struct packed {
    logic load_char;
    logic wr_term;
    logic wr_char;
    logic emit;
    src_t src;
    logic line;
    logic last;
    logic cur_inc;
    logic cur_dec;
    logic cur_clr;
    logic k_clr;
    logic k_inc;
    logic rd_k;
    logic pend_load;
  } cmd_t;

  typedef struct packed {
    logic is_cr;
    logic is_bs;
    logic is_ctrlp;
    logic is_print;
    logic cur_zero;
    logic can_store;
    logic recall_ok;
    logic dump_last;
    logic slot_free;
  } status_t;

endpackage

// File: rtl/console_line_editor.sv
// Top level of the line editor: stream ports, APB register and controller/datapath wiring.
// An accepted item is held in char_r and decoded before its first result is loaded into the result register.
// Only one item is in work at a time; each result of an item passes through the single result
// register, so a carriage return that dumps a full line holds off new input until its last result.
// Results stall the sequencer whenever a result is waiting and out_tready is low.
// Reset (rst_n low, synchronous) clears the line store, cursor and output valid; max_line_len is 32.
module console_line_editor import cle_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,     // [7:0] rx_char
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,    // [6:0] out_char, [7] zero fill
  output logic [0:0]        out_tuser,    // [0] is_line_byte
  output logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [LEN_W-1:0]  max_len_r;
  logic              cfg_wr;
  logic              reg_sel;
  cmd_t              cmd;
  status_t           st;
  logic [CHAR_W-1:0] out_char;
  logic              out_line;

  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[APB_AW-1] == REG_MAX_LINE_LEN);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr && reg_sel) begin
      max_len_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  assign cfg_prdata = reg_sel ? APB_DW'(max_len_r) : '0;

  cle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  cle_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_char      (in_tdata),
    .max_line_len (max_len_r),
    .cmd          (cmd),
    .st           (st),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_char     (out_char),
    .out_line     (out_line),
    .out_last     (out_tlast)
  );

  assign out_tdata = {1'b0, out_char};
  assign out_tuser = out_line;

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in work");

  // Stored line characters are always printable or recalled, never the terminator.
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[CHAR_W-1:0] != CH_NUL)
    else $error("terminator sent as a line byte");

  // A new result is only loaded when the previous one is gone or being taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.slot_free)
    else $error("result register overwritten");

endmodule

// File: rtl/cle_ctrl.sv
// Controller state machine: sequences decode, echo, erase, recall and line dump for each item.
module cle_ctrl import cle_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DECODE = 10'b0000000010,
    S_CR     = 10'b0000000100,
    S_LF     = 10'b0000001000,
    S_DUMP   = 10'b0000010000,
    S_BS_A   = 10'b0000100000,
    S_SP     = 10'b0001000000,
    S_BS_B   = 10'b0010000000,
    S_ECHO   = 10'b0100000000,
    S_RNEXT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.src   = SRC_CR;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_char = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.is_cr) begin
          cmd.wr_term = 1'b1;
          state_nxt   = S_CR;
        end else if (st.is_bs) begin
          state_nxt = st.cur_zero ? S_IDLE : S_BS_A;
        end else if (st.is_ctrlp) begin
          // The first recalled character is held back until we know if it is the last.
          if (st.recall_ok) begin
            cmd.pend_load = 1'b1;
            cmd.cur_inc   = 1'b1;
            state_nxt     = S_RNEXT;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (st.is_print && st.can_store) begin
          state_nxt = S_ECHO;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CR: begin
        if (st.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.src   = SRC_CR;
          state_nxt = S_LF;
        end
      end
      S_LF: begin
        cmd.k_clr = 1'b1;
        if (st.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.src   = SRC_LF;
          cmd.last  = st.cur_zero;
          state_nxt = st.cur_zero ? S_IDLE : S_DUMP;
        end
      end
      S_DUMP: begin
        cmd.rd_k = 1'b1;
        if (st.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.src   = SRC_STORE;
          cmd.line  = 1'b1;
          cmd.last  = st.dump_last;
          cmd.k_inc = 1'b1;
          if (st.dump_last) begin
            cmd.cur_clr = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_BS_A: begin
        if (st.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.src   = SRC_BS;
          state_nxt = S_SP;
        end
      end
      S_SP: begin
        if (st.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.src   = SRC_SP;
          state_nxt = S_BS_B;
        end
      end
      S_BS_B: begin
        if (st.slot_free) begin
          cmd.emit    = 1'b1;
          cmd.src     = SRC_BS;
          cmd.last    = 1'b1;
          cmd.cur_dec = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_ECHO: begin
        if (st.slot_free) begin
          cmd.emit    = 1'b1;
          cmd.src     = SRC_CHAR;
          cmd.last    = 1'b1;
          cmd.wr_char = 1'b1;
          cmd.cur_inc = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_RNEXT: begin
        if (st.slot_free) begin
          cmd.emit = 1'b1;
          cmd.src  = SRC_PEND;
          cmd.last = !st.recall_ok;
          if (st.recall_ok) begin
            cmd.pend_load = 1'b1;
            cmd.cur_inc   = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/cle_datapath.sv
// Datapath: line store, cursor, dump index, character decode and the output register.
module cle_datapath import cle_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [RX_W-1:0]   rx_char,
  input  logic [LEN_W-1:0]  max_line_len,
  input  cmd_t              cmd,
  output status_t           st,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_line,
  output logic              out_last
);

  logic [CHAR_W-1:0] store_r [LINE_DEPTH];
  logic [IDX_W-1:0]  cursor_r, cursor_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [CHAR_W-1:0] char_r;
  logic [CHAR_W-1:0] pend_r;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_line_r;
  logic              out_last_r;

  logic [IDX_W-1:0]  rd_addr;
  logic [CHAR_W-1:0] rd_data;
  logic [LEN_W-1:0]  lim;
  logic [LEN_W-1:0]  cap;
  logic [CHAR_W-1:0] emit_char;

  // Usable length is the register clipped to the store depth, minus one for the terminator.
  always_comb begin
    lim = (max_line_len > LEN_W'(LINE_DEPTH)) ? LEN_W'(LINE_DEPTH) : max_line_len;
    cap = (lim == '0) ? '0 : lim - LEN_W'(1);
  end

  assign rd_addr = cmd.rd_k ? k_r : cursor_r;
  assign rd_data = store_r[rd_addr];

  always_comb begin
    st.is_cr     = (char_r == CH_CR);
    st.is_bs     = (char_r == CH_BS) || (char_r == CH_DEL);
    st.is_ctrlp  = (char_r == CH_CTRLP);
    st.is_print  = ((char_r & PRINT_BITS) != '0);
    st.cur_zero  = (cursor_r == '0);
    st.can_store = (LEN_W'(cursor_r) < cap);
    st.recall_ok = (LEN_W'(cursor_r) < cap) && (rd_data != CH_NUL);
    st.dump_last = ((k_r + IDX_W'(1)) == cursor_r);
    st.slot_free = !out_valid_r || out_ready;
  end

  always_comb begin
    case (cmd.src)
      SRC_CR:    emit_char = CH_CR;
      SRC_LF:    emit_char = CH_LF;
      SRC_BS:    emit_char = CH_BS;
      SRC_SP:    emit_char = CH_SPACE;
      SRC_CHAR:  emit_char = char_r;
      SRC_STORE: emit_char = rd_data;
      SRC_PEND:  emit_char = pend_r;
      default:   emit_char = CH_NUL;
    endcase
  end

  always_comb begin
    cursor_nxt = cursor_r;
    if (cmd.cur_clr) begin
      cursor_nxt = '0;
    end else if (cmd.cur_inc) begin
      cursor_nxt = cursor_r + IDX_W'(1);
    end else if (cmd.cur_dec) begin
      cursor_nxt = cursor_r - IDX_W'(1);
    end
  end

  always_comb begin
    k_nxt = k_r;
    if (cmd.k_clr) begin
      k_nxt = '0;
    end else if (cmd.k_inc) begin
      k_nxt = k_r + IDX_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
        store_r[i] <= CH_NUL;
      end
    end else begin
      cursor_r    <= cursor_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.wr_term) begin
        store_r[cursor_r] <= CH_NUL;
      end else if (cmd.wr_char) begin
        store_r[cursor_r] <= char_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      char_r <= rx_char[CHAR_W-1:0];
    end
    if (cmd.pend_load) begin
      pend_r <= rd_data;
    end
    if (cmd.emit) begin
      out_char_r <= emit_char;
      out_line_r <= cmd.line;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_line  = out_line_r;
  assign out_last  = out_last_r;

endmodule

// File: bench/console_line_editor_tb.sv
// Self-checking testbench for the console line editor: stream stimulus, APB limit writes, checks.
module console_line_editor_tb;
  import cle_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              line;
    logic              last;
  } echo_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;     // [7:0] rx_char
  logic              out_tvalid;
  logic              out_tready;
  logic [7:0]        out_tdata;    // [6:0] out_char, [7] zero fill
  logic [0:0]        out_tuser;    // [0] is_line_byte
  logic              out_tlast;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // Predicted editor state.
  logic [CHAR_W-1:0] line_mem [LINE_DEPTH];
  int                edit_pos;
  logic [LEN_W-1:0]  len_reg;

  echo_t             echo_due [$];
  logic [7:0]        keys_pending [$];
  int                keys_offered;
  int                keys_taken;
  int                keys_live;
  int                mismatches;
  int                key_gap;
  bit                key_burst;
  int                tx_gap;
  bit                tx_burst;
  int                tx_hold;

  console_line_editor u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_len(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom % 16;
    if (r < 10) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Works out the echo and line bytes one received byte produces.
  function automatic void edit_line(input logic [7:0] rx);
    logic [CHAR_W-1:0] c;
    int                lim;
    int                cap;
    echo_t             burst [$];
    c = rx[CHAR_W-1:0];
    lim = (int'(len_reg) > LINE_DEPTH) ? LINE_DEPTH : int'(len_reg);
    cap = (lim == 0) ? 0 : lim - 1;
    if (c == CH_CR) begin
      burst.push_back(echo_t'{CH_CR, 1'b0, 1'b0});
      burst.push_back(echo_t'{CH_LF, 1'b0, 1'b0});
      line_mem[edit_pos] = CH_NUL;
      for (int k = 0; k < edit_pos; k++) burst.push_back(echo_t'{line_mem[k], 1'b1, 1'b0});
      edit_pos = 0;
    end else if (c == CH_DEL || c == CH_BS) begin
      if (edit_pos > 0) begin
        burst.push_back(echo_t'{CH_BS, 1'b0, 1'b0});
        burst.push_back(echo_t'{CH_SPACE, 1'b0, 1'b0});
        burst.push_back(echo_t'{CH_BS, 1'b0, 1'b0});
        edit_pos--;
      end
    end else if (c == CH_CTRLP) begin
      while (edit_pos < cap && line_mem[edit_pos] != CH_NUL) begin
        burst.push_back(echo_t'{line_mem[edit_pos], 1'b0, 1'b0});
        edit_pos++;
      end
    end else if ((c & PRINT_BITS) != CH_NUL && edit_pos < cap) begin
      burst.push_back(echo_t'{c, 1'b0, 1'b0});
      line_mem[edit_pos] = c;
      edit_pos++;
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) echo_due.push_back(burst[i]);
  endfunction

  // Checks results and feeds the predictor with every accepted item and register write.
  always @(posedge clk) begin : watch
    echo_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (echo_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item, expected none, got tdata %h tuser %b tlast %b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        e = echo_due.pop_front();
        if (out_tdata !== {1'b0, e.ch}) begin
          mismatches++;
          $display("%0t: out_char expected %h, got %h", $time, {1'b0, e.ch}, out_tdata);
        end
        if (out_tuser[0] !== e.line) begin
          mismatches++;
          $display("%0t: is_line_byte expected %b, got %b", $time, e.line, out_tuser[0]);
        end
        if (out_tlast !== e.last) begin
          mismatches++;
          $display("%0t: last expected %b, got %b", $time, e.last, out_tlast);
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      edit_line(in_tdata);
      keys_taken++;
    end
    if (rst_n && cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
      len_reg = cfg_pwdata[LEN_W-1:0];
  end

  // Sender: offers queued bytes with random gaps and burst stretches.
  always @(negedge clk) begin : send_keys
    logic       nv;
    logic [7:0] nd;
    nv = in_tvalid;
    nd = in_tdata;
    if (in_tvalid && keys_taken == keys_offered) nv = 1'b0;
    if (!nv && rst_n) begin
      if (key_gap > 0) begin
        key_gap--;
      end else if (keys_pending.size() > 0) begin
        nd = keys_pending.pop_front();
        nv = 1'b1;
        keys_offered++;
        if ($urandom % 40 == 0) key_burst = !key_burst;
        key_gap = idle_len(key_burst);
      end
    end
    in_tvalid <= nv;
    in_tdata  <= nd;
  end

  // Receiver: random stalls, plus the long hold-off when one is requested.
  always @(negedge clk) begin
    if (tx_hold > 0) begin
      out_tready <= 1'b0;
      tx_hold--;
    end else if (tx_gap > 0) begin
      out_tready <= 1'b0;
      tx_gap--;
    end else begin
      out_tready <= 1'b1;
      if ($urandom % 60 == 0) tx_burst = !tx_burst;
      if (!tx_burst && $urandom % 4 == 0) tx_gap = idle_len(1'b0);
    end
  end

  task automatic press(input logic [7:0] b);
    logic [CHAR_W-1:0] c;
    c = b[CHAR_W-1:0];
    keys_pending.push_back(b);
    if (c == CH_CR || c == CH_BS || c == CH_DEL || c == CH_CTRLP || (c & PRINT_BITS) != CH_NUL)
      keys_live++;
  endtask

  // Bit 7 is don't-care for the block, so it is set now and then.
  task automatic press7(input logic [CHAR_W-1:0] c);
    press({($urandom % 6 == 0) ? 1'b1 : 1'b0, c});
  endtask

  task automatic settle();
    while (keys_pending.size() != 0 || in_tvalid || echo_due.size() != 0) @(posedge clk);
    // Ignored bytes leave no result behind, so let the block finish them.
    repeat (10) @(posedge clk);
  endtask

  task automatic set_len(input logic [APB_DW-1:0] wd);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= APB_AW'(REG_MAX_LINE_LEN) << 2;
    cfg_pwdata  <= wd;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[LEN_W-1:0] !== wd[LEN_W-1:0]) begin
      mismatches++;
      $display("%0t: max_line_len read expected %h, got %h", $time, wd[LEN_W-1:0],
               cfg_prdata[LEN_W-1:0]);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Mostly typed lines with edits and recalls, the rest raw noise.
  task automatic type_lines(input int n);
    int first;
    int len;
    int r;
    first = keys_live;
    while (keys_live - first < n) begin
      if ($urandom % 100 < 75) begin
        if ($urandom % 10 < 3) press7(CH_CTRLP);
        r = $urandom % 10;
        len = (r < 7) ? $urandom_range(0, 8) : (r < 9) ? $urandom_range(9, 20)
                                                        : $urandom_range(30, 40);
        for (int i = 0; i < len; i++) begin
          r = $urandom % 20;
          if (r == 0) press7(CH_BS);
          else if (r == 1) press7(CH_DEL);
          else if (r == 2) press7(CH_CTRLP);
          else press7(CHAR_W'($urandom_range(32'h20, 32'h7e)));
        end
        if ($urandom % 100 < 85) press7(CH_CR);
      end else begin
        repeat ($urandom_range(1, 4)) press(8'($urandom));
      end
    end
  endtask

  initial begin
    int lims [7];
    int phase;
    lims = '{63, 1, 0, 2, 33, 32, 31};
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    foreach (line_mem[i]) line_mem[i] = CH_NUL;
    edit_pos     = 0;
    len_reg      = MAX_LEN_RESET;
    keys_offered = 0;
    keys_taken   = 0;
    keys_live    = 0;
    mismatches   = 0;
    key_gap      = 0;
    key_burst    = 1'b0;
    tx_gap       = 0;
    tx_burst     = 1'b0;
    tx_hold      = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty-line keys, ignored controls, masked bit 7, edits, recall, then a line left open.
    press({1'b0, CH_CTRLP});
    press({1'b0, CH_BS});
    press({1'b0, CH_DEL});
    press(8'h00);
    press(8'h1f);
    press(8'h20);
    press(8'h7e);
    press(8'hff);
    press(8'h41);
    press({1'b1, CH_BS});
    press(8'h62);
    press({1'b1, CH_CR});
    press({1'b1, CH_CTRLP});
    press({1'b0, CH_BS});
    press({1'b0, CH_CR});
    press({1'b0, CH_LF});
    press(8'h80);
    press(8'h78);
    press(8'h79);
    press(8'h7a);
    settle();

    // Each phase starts from whatever cursor the last one left, so a lowered limit
    // often lands below the cursor.
    phase = 0;
    while (keys_live < 350) begin
      if (phase < 7) set_len(APB_DW'(lims[phase]));
      else if ($urandom % 10 < 6) set_len({26'($urandom), LEN_W'($urandom_range(3, 32))});
      else set_len({26'($urandom), LEN_W'($urandom)});
      type_lines($urandom_range(30, 45));
      if (phase == 5) begin
        @(posedge clk);
        tx_hold = 300;
      end
      settle();
      phase++;
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0 && echo_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
rtl/cle_pkg.sv
rtl/cle_ctrl.sv
rtl/cle_datapath.sv
rtl/console_line_editor.sv
bench/console_line_editor_tb.sv
